/* rtl/phm_pkg.sv */
// ----------------------------------------------------------------------------
// phm_pkg
// Shared widths, controller states and the command/status bundles of the
// peak and half-maximum edge finder.
// ----------------------------------------------------------------------------
`default_nettype none

package phm_pkg;

  // Field widths
  localparam int AMP_W  = 16;
  localparam int POS_W  = 16;

  // Derived widths: doubled amplitudes, product, divider step counter, edge width
  localparam int NUM_W  = AMP_W + 1;
  localparam int PROD_W = NUM_W + POS_W;
  localparam int CNT_W  = $clog2(POS_W);
  localparam int WID_W  = POS_W + 1;

  // Controller states
  typedef enum logic [2:0] {
    ST_RUN,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_PUSH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;   // sample transfer this cycle
    logic prep;     // form numerator, denominator, distance
    logic mul;      // register the product into the divider
    logic div;      // one restoring division step
    logic load;     // load the result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic found;    // latched run had a crossing
    logic div_last; // final division step this cycle
  } sts_t;

endpackage

`default_nettype wire

/* rtl/phm_ifs.sv */
// ----------------------------------------------------------------------------
// phm_sample_if / phm_result_if
// Valid/ready channels for samples in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface phm_sample_if;
  logic                        valid;
  logic                        ready;
  logic [phm_pkg::POS_W-1:0]   sample_pos;
  logic [phm_pkg::AMP_W-1:0]   sample_amp;
  logic                        run_last;

  modport source (output valid, sample_pos, sample_amp, run_last, input ready);
  modport sink   (input valid, sample_pos, sample_amp, run_last, output ready);
endinterface

interface phm_result_if;
  logic                        valid;
  logic                        ready;
  logic [phm_pkg::POS_W-1:0]   peak_pos;
  logic [phm_pkg::POS_W-1:0]   half_pos;
  logic signed [phm_pkg::WID_W-1:0] edge_width;
  logic                        half_found;

  modport source (output valid, peak_pos, half_pos, edge_width, half_found,
                  input ready);
  modport sink   (input valid, peak_pos, half_pos, edge_width, half_found,
                  output ready);
endinterface

`default_nettype wire

/* rtl/phm_ctrl.sv */
// ----------------------------------------------------------------------------
// phm_ctrl
// Controller: takes samples, sequences the end-of-run interpolation and
// owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module phm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          sample_valid,
  input  wire logic          run_last,
  output logic               sample_ready,
  output logic               result_valid,
  input  wire logic          result_ready,
  output phm_pkg::cmd_t      cmd,
  input  wire phm_pkg::sts_t sts
);

  phm_pkg::state_t state, state_next;
  logic            slot_free;

  assign slot_free = !result_valid || result_ready;

  // State register and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= phm_pkg::ST_RUN;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      phm_pkg::ST_RUN: begin
        if (sample_valid && run_last) state_next = phm_pkg::ST_PREP;
      end
      phm_pkg::ST_PREP: begin
        state_next = sts.found ? phm_pkg::ST_MUL : phm_pkg::ST_PUSH;
      end
      phm_pkg::ST_MUL: begin
        state_next = phm_pkg::ST_DIV;
      end
      phm_pkg::ST_DIV: begin
        if (sts.div_last) state_next = phm_pkg::ST_PUSH;
      end
      phm_pkg::ST_PUSH: begin
        if (slot_free) state_next = phm_pkg::ST_RUN;
      end
      default: begin
        state_next = phm_pkg::ST_RUN;
      end
    endcase
  end

  // Outputs
  always_comb begin
    sample_ready = 1'b0;
    cmd          = '0;
    case (state)
      phm_pkg::ST_RUN: begin
        sample_ready = 1'b1;
        cmd.accept   = sample_valid;
      end
      phm_pkg::ST_PREP: cmd.prep = 1'b1;
      phm_pkg::ST_MUL:  cmd.mul  = 1'b1;
      phm_pkg::ST_DIV:  cmd.div  = 1'b1;
      phm_pkg::ST_PUSH: cmd.load = slot_free;
      default: begin
        sample_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/phm_dp.sv */
// ----------------------------------------------------------------------------
// phm_dp
// Datapath: peak and crossing tracker, end-of-run operand latch,
// multiplier, bit-serial divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module phm_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire phm_pkg::cmd_t                cmd,
  output phm_pkg::sts_t                     sts,
  input  wire logic [phm_pkg::POS_W-1:0]    sample_pos,
  input  wire logic [phm_pkg::AMP_W-1:0]    sample_amp,
  input  wire logic                         run_last,
  output logic [phm_pkg::POS_W-1:0]         peak_pos,
  output logic [phm_pkg::POS_W-1:0]         half_pos,
  output logic signed [phm_pkg::WID_W-1:0]  edge_width,
  output logic                              half_found
);

  // Tracker state
  logic [phm_pkg::AMP_W-1:0] peak_value,    peak_value_next;
  logic [phm_pkg::POS_W-1:0] peak_position, peak_position_next;
  logic [phm_pkg::POS_W-1:0] prev_pos;
  logic [phm_pkg::AMP_W-1:0] prev_amp;
  logic                      crossing_seen, crossing_seen_next;
  logic [phm_pkg::POS_W-1:0] before_pos,    before_pos_next;
  logic [phm_pkg::AMP_W-1:0] before_amp,    before_amp_next;
  logic [phm_pkg::POS_W-1:0] after_pos,     after_pos_next;
  logic [phm_pkg::AMP_W-1:0] after_amp,     after_amp_next;

  // Operands latched at the end of a run
  logic [phm_pkg::AMP_W-1:0] w_peak_val;
  logic [phm_pkg::POS_W-1:0] w_peak_pos;
  logic                      w_found;
  logic [phm_pkg::POS_W-1:0] w_bpos;
  logic [phm_pkg::AMP_W-1:0] w_bamp;
  logic [phm_pkg::POS_W-1:0] w_apos;
  logic [phm_pkg::AMP_W-1:0] w_aamp;

  // Interpolation operands and divider
  logic [phm_pkg::NUM_W-1:0] num;
  logic [phm_pkg::NUM_W-1:0] den;
  logic [phm_pkg::POS_W-1:0] dx;
  logic                      dir_up;
  logic [phm_pkg::NUM_W-1:0] rem;
  logic [phm_pkg::POS_W-1:0] quo;
  logic [phm_pkg::CNT_W-1:0] cnt;
  logic [phm_pkg::NUM_W:0]   shifted;
  logic                      ge;
  logic [phm_pkg::NUM_W:0]   diff;
  logic [phm_pkg::PROD_W-1:0] product;
  logic [phm_pkg::POS_W-1:0] half_calc;
  logic                      is_peak;
  logic                      is_cross;

  // Per-sample tracker update
  always_comb begin
    is_peak  = sample_amp > peak_value;
    is_cross = ({sample_amp, 1'b0} < {1'b0, peak_value}) && !crossing_seen;
    peak_value_next    = peak_value;
    peak_position_next = peak_position;
    crossing_seen_next = crossing_seen;
    before_pos_next    = before_pos;
    before_amp_next    = before_amp;
    after_pos_next     = after_pos;
    after_amp_next     = after_amp;
    if (is_peak) begin
      peak_value_next    = sample_amp;
      peak_position_next = sample_pos;
      crossing_seen_next = 1'b0;
    end else if (is_cross) begin
      before_pos_next    = prev_pos;
      before_amp_next    = prev_amp;
      after_pos_next     = sample_pos;
      after_amp_next     = sample_amp;
      crossing_seen_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.accept && run_last)) begin
      peak_value    <= '0;
      peak_position <= '0;
      prev_pos      <= '0;
      prev_amp      <= '0;
      crossing_seen <= 1'b0;
      before_pos    <= '0;
      before_amp    <= '0;
      after_pos     <= '0;
      after_amp     <= '0;
    end else if (cmd.accept) begin
      peak_value    <= peak_value_next;
      peak_position <= peak_position_next;
      prev_pos      <= sample_pos;
      prev_amp      <= sample_amp;
      crossing_seen <= crossing_seen_next;
      before_pos    <= before_pos_next;
      before_amp    <= before_amp_next;
      after_pos     <= after_pos_next;
      after_amp     <= after_amp_next;
    end
  end

  // Latch the finished run's figures, including its last sample
  always_ff @(posedge clk) begin
    if (cmd.accept && run_last) begin
      w_peak_val <= peak_value_next;
      w_peak_pos <= peak_position_next;
      w_found    <= crossing_seen_next;
      w_bpos     <= before_pos_next;
      w_bamp     <= before_amp_next;
      w_apos     <= after_pos_next;
      w_aamp     <= after_amp_next;
    end
  end

  // Interpolation operands: 2*eA - max, 2*(eA - eC), |xC - xA|
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      num    <= {w_bamp, 1'b0} - {1'b0, w_peak_val};
      den    <= {w_bamp - w_aamp, 1'b0};
      dir_up <= w_apos >= w_bpos;
      dx     <= (w_apos >= w_bpos) ? (w_apos - w_bpos) : (w_bpos - w_apos);
    end
  end

  assign product = phm_pkg::PROD_W'(num) * phm_pkg::PROD_W'(dx);

  // Restoring division step; the quotient stays below dx
  assign shifted = {rem, quo[phm_pkg::POS_W-1]};
  assign ge      = shifted >= {1'b0, den};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      {rem, quo} <= product;
      cnt        <= '0;
    end else if (cmd.div) begin
      rem <= ge ? diff[phm_pkg::NUM_W-1:0] : shifted[phm_pkg::NUM_W-1:0];
      quo <= {quo[phm_pkg::POS_W-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

  assign sts.found    = w_found;
  assign sts.div_last = (cnt == phm_pkg::CNT_W'(phm_pkg::POS_W - 1));

  // Crossing position: floor toward the lower coordinate
  always_comb begin
    if (den == '0) begin
      half_calc = w_bpos;
    end else if (dir_up) begin
      half_calc = w_bpos + quo;
    end else begin
      half_calc = w_bpos - quo - phm_pkg::POS_W'(rem != '0);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      peak_pos   <= w_peak_pos;
      half_found <= w_found;
      if (w_found) begin
        half_pos   <= half_calc;
        edge_width <= {1'b0, half_calc} - {1'b0, w_peak_pos};
      end else begin
        half_pos   <= '0;
        edge_width <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/peak_half_max_edge_finder.sv */
// ----------------------------------------------------------------------------
// peak_half_max_edge_finder
// Tracks the peak of a sample run and the first falling half-maximum
// crossing after it; at the end of the run interpolates the crossing.
//
//   channel   dir   payload                                      handshake
//   sample    in    sample_pos, sample_amp, run_last             valid/ready
//   result    out   peak_pos, half_pos, edge_width, half_found   valid/ready
//
// Samples that do not end a run are taken one per cycle in ST_RUN. A run's
// last sample leads to ST_PREP, then, with a crossing, ST_MUL and ST_DIV
// of the one-bit-per-cycle divider, then ST_PUSH. Reset (rst, synchronous)
// clears the tracker and empties the result register. The result
// register holds a result until it is taken; the next run's samples are
// taken meanwhile, and only the next run end waits for the register to free up.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_half_max_edge_finder (
  input  wire logic   clk,
  input  wire logic   rst,
  phm_sample_if.sink  sample,
  phm_result_if.source result
);

  phm_pkg::cmd_t cmd;
  phm_pkg::sts_t sts;

  // Controller
  phm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample.valid),
    .run_last     (sample.run_last),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  // Datapath
  phm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .sample_pos (sample.sample_pos),
    .sample_amp (sample.sample_amp),
    .run_last   (sample.run_last),
    .peak_pos   (result.peak_pos),
    .half_pos   (result.half_pos),
    .edge_width (result.edge_width),
    .half_found (result.half_found)
  );

endmodule

`default_nettype wire
